// ----- design/contact_pair_event_differ_unit_macros.svh -----
// Assertion macros for the contact pair event differ.
`ifndef CONTACT_PAIR_EVENT_DIFFER_UNIT_MACROS_SVH
`define CONTACT_PAIR_EVENT_DIFFER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define CPED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define CPED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CPED_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/cped_pkg.sv -----
// Shared types and constants of the contact pair event differ.
package cped_pkg;
	localparam int SLOT_COUNT_DEF = 1024;
	localparam int MAX_PAIRS_DEF  = 32;
	localparam int SLOT_W         = 10;
	localparam int GEN_W          = 32;
	localparam int CAP_W          = 11;

	localparam logic [1:0] CMD_PAIR = 2'd0;
	localparam logic [1:0] CMD_SLOT = 2'd1;
	localparam logic [1:0] CMD_EOF  = 2'd2;

	localparam logic [2:0] EV_COLL_ENTER = 3'd0;
	localparam logic [2:0] EV_COLL_EXIT  = 3'd2;
	localparam logic [2:0] EV_TRIG_ENTER = 3'd3;
	localparam logic [2:0] EV_TRIG_EXIT  = 3'd5;

	localparam logic CFG_CAPACITY = 1'b0;
	localparam logic CFG_TAG      = 1'b1;

	// one request as queued between front and back
	typedef struct packed {
		logic [1:0]        cmd;
		logic [SLOT_W-1:0] sa;
		logic [GEN_W-1:0]  ga;
		logic [SLOT_W-1:0] sb;
		logic [GEN_W-1:0]  gb;
		logic              trig;
		logic              alive;
	} req_t;

	// one emitted event
	typedef struct packed {
		logic [2:0]        kind;
		logic [SLOT_W-1:0] ss;
		logic [GEN_W-1:0]  sg;
		logic [SLOT_W-1:0] os;
		logic [GEN_W-1:0]  og;
		logic              trig;
		logic              mir;
		logic              dropped;
		logic              last;
	} evt_t;
endpackage

// ----- design/cped_queue.sv -----
// Short request queue between the front and the back.
module cped_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  cped_pkg::req_t  in_req,
	output logic            out_valid,
	input  logic            out_take,
	output cped_pkg::req_t  out_req
);
	cped_pkg::req_t mem_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_req   = mem_q[rd_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && out_take;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- design/cped_front.sv -----
// Front: takes requests, drops unused commands, classifies into the queue.
module cped_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	output logic            stall,
	input  logic [1:0]      cmd,
	input  logic [9:0]      first_slot,
	input  logic [31:0]     first_gen,
	input  logic [9:0]      second_slot,
	input  logic [31:0]     second_gen,
	input  logic            trigger_flag,
	input  logic            alive_flag,
	output logic            q_valid,
	input  logic            q_stall,
	output cped_pkg::req_t  q_req
);
	cped_pkg::req_t req_s1;
	logic           vld_s1;
	logic           known;

	// a command code of no meaning is taken and forgotten
	assign known = (cmd == cped_pkg::CMD_PAIR) || (cmd == cped_pkg::CMD_SLOT)
		|| (cmd == cped_pkg::CMD_EOF);
	assign stall   = vld_s1 && q_stall;
	assign q_valid = vld_s1;
	assign q_req   = req_s1;

	always_ff @(posedge clk) begin
		if (valid && !stall) begin
			req_s1 <= '{cmd: cmd, sa: first_slot, ga: first_gen, sb: second_slot,
				gb: second_gen, trig: trigger_flag, alive: alive_flag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= valid && known;
		end
	end
endmodule

// ----- design/cped_back.sv -----
// Back: slot table, pair tables, lookup and end of frame sweep, event output.
module cped_back #(
	parameter int SLOT_COUNT = cped_pkg::SLOT_COUNT_DEF,
	parameter int MAX_PAIRS  = cped_pkg::MAX_PAIRS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_take,
	input  cped_pkg::req_t              q_req,
	input  logic [cped_pkg::CAP_W-1:0]  capacity,
	output logic                        ev_valid,
	input  logic                        ev_stall,
	output cped_pkg::evt_t              ev
);
`include "contact_pair_event_differ_unit_macros.svh"
	localparam int SA_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PI_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int PC_W = $clog2(MAX_PAIRS + 1);
	localparam int SW   = cped_pkg::SLOT_W;
	localparam int GW   = cped_pkg::GEN_W;
	localparam int EW   = 2 * SW + 2 * GW + 1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_LIVE_A, ST_LIVE_B, ST_LIVE_CHK, ST_SRCH, ST_SRCH_CHK,
		ST_EMIT_A, ST_EMIT_B, ST_EOF_RD, ST_EOF_INNER, ST_EOF_LV_A, ST_EOF_LV_B,
		ST_EOF_EMIT, ST_EOF_SWAP
	} state_t;

	state_t state_q;

	// slot table: one write/read port memory, registered read
	logic [GW:0]  slot_mem [SLOT_COUNT];
	logic [GW:0]  slot_rd_q;
	logic [SA_W-1:0] slot_addr;
	logic         slot_we;
	logic [GW:0]  slot_wd;
	logic [SA_W-1:0] clr_q;

	// two pair banks; bank sel_q is the previous frame
	logic [EW-1:0] pair_mem0 [MAX_PAIRS];
	logic [EW-1:0] pair_mem1 [MAX_PAIRS];
	logic [EW-1:0] prev_rd_q, next_rd_q;
	logic          sel_q;
	logic [PC_W-1:0] prev_cnt_q, next_cnt_q;
	logic [PI_W-1:0] prev_addr, next_addr;
	logic            next_we;
	logic [EW-1:0]   next_wd;

	cped_pkg::req_t  cur_q;
	logic [PC_W-1:0] i_q, k_q;
	logic            live_a_q, stay_q, drop_q, lb_q;
	logic [EW-1:0]   ent_q;
	logic            ev_valid_q;
	cped_pkg::evt_t  ev_q;
	logic            ev_free;
	logic            ev_load;
	logic            has_more;

	function automatic logic in_range(logic [SW-1:0] s, logic [cped_pkg::CAP_W-1:0] cap);
		in_range = ({1'b0, s} < cap) && (32'(s) < 32'(SLOT_COUNT));
	endfunction

	assign ev_free  = !ev_valid_q || !ev_stall;
	assign ev_valid = ev_valid_q;
	assign ev       = ev_q;
	assign q_take   = (state_q == ST_IDLE);

	// address and write selection for the memories
	always_comb begin
		slot_we   = 1'b0;
		slot_addr = SA_W'(cur_q.sa);
		slot_wd   = {q_req.alive, q_req.ga};
		next_we   = 1'b0;
		next_wd   = {cur_q.trig, cur_q.gb, cur_q.ga, cur_q.sb, cur_q.sa};
		prev_addr = PI_W'(i_q);
		next_addr = PI_W'(next_cnt_q);
		ev_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				slot_we   = 1'b1;
				slot_addr = clr_q;
				slot_wd   = '0;
			end
			ST_IDLE: begin
				slot_addr = SA_W'(q_req.sa);
				slot_we   = q_valid && q_req.cmd == cped_pkg::CMD_SLOT
					&& 32'(q_req.sa) < 32'(SLOT_COUNT);
			end
			ST_LIVE_A, ST_LIVE_B: slot_addr = SA_W'(cur_q.sb);
			ST_SRCH_CHK: next_we = next_cnt_q < PC_W'(MAX_PAIRS);
			ST_EMIT_A, ST_EMIT_B, ST_EOF_SWAP: ev_load = ev_free;
			ST_EOF_RD: begin
				next_addr = '0;
			end
			ST_EOF_INNER: begin
				next_addr = PI_W'(k_q + 1'b1);
				slot_addr = SA_W'(prev_rd_q[SW-1:0]);
			end
			ST_EOF_LV_A: slot_addr = SA_W'(ent_q[2*SW-1:SW]);
			ST_EOF_EMIT: ev_load = ev_free && (live_a_q || lb_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_addr] <= slot_wd;
		end
		slot_rd_q <= slot_mem[slot_addr];
		if (next_we) begin
			if (sel_q) pair_mem0[next_addr] <= next_wd;
			else       pair_mem1[next_addr] <= next_wd;
		end
		prev_rd_q <= sel_q ? pair_mem1[prev_addr] : pair_mem0[prev_addr];
		next_rd_q <= sel_q ? pair_mem0[next_addr] : pair_mem1[next_addr];
	end

	assign has_more = (i_q + 1'b1) < prev_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			sel_q      <= 1'b0;
			prev_cnt_q <= '0;
			next_cnt_q <= '0;
			ev_valid_q <= 1'b0;
			i_q        <= '0;
			k_q        <= '0;
			live_a_q   <= 1'b0;
			stay_q     <= 1'b0;
			drop_q     <= 1'b0;
			lb_q       <= 1'b0;
			cur_q      <= '0;
			ent_q      <= '0;
			ev_q       <= '0;
		end else begin
			ev_valid_q <= ev_load || (ev_valid_q && ev_stall);
			case (state_q)
				ST_CLEAR: begin
					// one slot entry zeroed per cycle after reset
					clr_q <= clr_q + 1'b1;
					if (clr_q == SA_W'(SLOT_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					i_q <= '0;
					k_q <= '0;
					if (q_valid) begin
						cur_q <= q_req;
						if (q_req.cmd == cped_pkg::CMD_PAIR) begin
							state_q <= ST_LIVE_A;
						end else if (q_req.cmd == cped_pkg::CMD_EOF) begin
							state_q <= (prev_cnt_q != '0) ? ST_EOF_RD : ST_EOF_SWAP;
						end
					end
				end
				ST_LIVE_A: begin
					live_a_q <= slot_rd_q[GW] && slot_rd_q[GW-1:0] == cur_q.ga
						&& in_range(cur_q.sa, capacity);
					state_q <= ST_LIVE_B;
				end
				ST_LIVE_B: begin
					state_q <= ST_LIVE_CHK;
				end
				ST_LIVE_CHK: begin
					stay_q <= 1'b0;
					if (live_a_q && slot_rd_q[GW] && slot_rd_q[GW-1:0] == cur_q.gb
						&& in_range(cur_q.sb, capacity)) begin
						state_q <= (prev_cnt_q != '0) ? ST_SRCH : ST_SRCH_CHK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SRCH: begin
					// read of entry i is in flight
					state_q <= ST_SRCH_CHK;
				end
				ST_SRCH_CHK: begin
					if (!stay_q && has_more && !(prev_rd_q[EW-2:0]
						== {cur_q.gb, cur_q.ga, cur_q.sb, cur_q.sa})) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_SRCH;
					end else begin
						if (i_q < prev_cnt_q && prev_rd_q[EW-2:0]
							== {cur_q.gb, cur_q.ga, cur_q.sb, cur_q.sa}) begin
							stay_q <= 1'b1;
						end
						drop_q <= !(next_cnt_q < PC_W'(MAX_PAIRS));
						if (next_cnt_q < PC_W'(MAX_PAIRS)) begin
							next_cnt_q <= next_cnt_q + 1'b1;
						end
						state_q <= ST_EMIT_A;
					end
				end
				ST_EMIT_A: begin
					if (ev_free) begin
						ev_q <= '{kind: (cur_q.trig ? cped_pkg::EV_TRIG_ENTER
							: cped_pkg::EV_COLL_ENTER) + {2'b0, stay_q},
							ss: cur_q.sa, sg: cur_q.ga, os: cur_q.sb, og: cur_q.gb,
							trig: cur_q.trig, mir: 1'b0, dropped: drop_q, last: 1'b0};
						state_q <= ST_EMIT_B;
					end
				end
				ST_EMIT_B: begin
					if (ev_free) begin
						ev_q <= '{kind: ev_q.kind, ss: cur_q.sb, sg: cur_q.gb,
							os: cur_q.sa, og: cur_q.ga, trig: cur_q.trig, mir: 1'b1,
							dropped: drop_q, last: 1'b1};
						state_q <= ST_IDLE;
					end
				end
				ST_EOF_RD: begin
					// prev entry i and next entry 0 reads in flight
					k_q     <= '0;
					state_q <= ST_EOF_INNER;
				end
				ST_EOF_INNER: begin
					if (k_q == '0) begin
						ent_q <= prev_rd_q;
					end
					if (k_q < next_cnt_q && next_rd_q[EW-2:0]
						== (k_q == '0 ? prev_rd_q[EW-2:0] : ent_q[EW-2:0])) begin
						state_q  <= ST_EOF_EMIT;
						live_a_q <= 1'b0;
						lb_q     <= 1'b0;
					end else if (k_q + 1'b1 < next_cnt_q) begin
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= ST_EOF_LV_A;
					end
				end
				ST_EOF_LV_A: begin
					live_a_q <= slot_rd_q[GW] && slot_rd_q[GW-1:0] == ent_q[2*SW+GW-1:2*SW]
						&& in_range(ent_q[SW-1:0], capacity);
					state_q <= ST_EOF_LV_B;
				end
				ST_EOF_LV_B: begin
					// B slot read issued in the previous state
					lb_q <= slot_rd_q[GW]
						&& slot_rd_q[GW-1:0] == ent_q[2*SW+2*GW-1:2*SW+GW]
						&& in_range(ent_q[2*SW-1:SW], capacity);
					state_q <= ST_EOF_EMIT;
				end
				ST_EOF_EMIT: begin
					if (live_a_q) begin
						if (ev_free) begin
							ev_q <= '{kind: ent_q[EW-1] ? cped_pkg::EV_TRIG_EXIT
								: cped_pkg::EV_COLL_EXIT, ss: ent_q[SW-1:0],
								sg: ent_q[2*SW+GW-1:2*SW], os: ent_q[2*SW-1:SW],
								og: ent_q[2*SW+2*GW-1:2*SW+GW], trig: ent_q[EW-1],
								mir: 1'b0, dropped: 1'b0, last: 1'b0};
							live_a_q <= 1'b0;
						end
					end else if (lb_q) begin
						if (ev_free) begin
							ev_q <= '{kind: ent_q[EW-1] ? cped_pkg::EV_TRIG_EXIT
								: cped_pkg::EV_COLL_EXIT, ss: ent_q[2*SW-1:SW],
								sg: ent_q[2*SW+2*GW-1:2*SW+GW], os: ent_q[SW-1:0],
								og: ent_q[2*SW+GW-1:2*SW], trig: ent_q[EW-1],
								mir: 1'b1, dropped: 1'b0, last: 1'b0};
							lb_q <= 1'b0;
						end
					end else if (ev_free) begin
						if (has_more) begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_EOF_RD;
						end else begin
							state_q <= ST_EOF_SWAP;
						end
					end
				end
				ST_EOF_SWAP: begin
					// marker: the top level turns it into the last flag of the final exit
					if (ev_free) begin
						ev_q <= '{kind: cped_pkg::EV_COLL_EXIT, ss: '0, sg: '0, os: '0,
							og: '0, trig: 1'b0, mir: 1'b1, dropped: 1'b1, last: 1'b1};
						sel_q      <= ~sel_q;
						prev_cnt_q <= next_cnt_q;
						next_cnt_q <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CPED_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, next_cnt_q <= PC_W'(MAX_PAIRS))
	`CPED_ASSERT_IMP(a_take_idle, clk, arst_n, q_take, state_q == ST_IDLE)
	`CPED_ASSERT_NEXT(a_pair_b, clk, arst_n, state_q == ST_EMIT_A && ev_free,
		state_q == ST_EMIT_B)
endmodule

// ----- design/contact_pair_event_differ_unit.sv -----
// Top level of the contact pair event differ.
// Contact pair event differ: turns per-frame contact pairs into ENTER, STAY and
// EXIT events. A front stage takes requests into a two-entry queue; a back
// sequencer executes them one at a time. After reset the back zeroes the slot
// table before it takes a request; the front and queue hold up to three
// requests meanwhile. A contact pair searches the previous-frame pairs, ending
// early on a hit, and is sent as two events; an end of frame looks up each
// previous pair in the next table and sends EXIT events for one not found
// again. Each event waits one stage in an output register until the next is
// known. End of frame ends with an internal marker that retags the final EXIT
// as last; with no EXIT no event is sent.
module contact_pair_event_differ_unit #(
	parameter int SLOT_COUNT = cped_pkg::SLOT_COUNT_DEF,
	parameter int MAX_PAIRS  = cped_pkg::MAX_PAIRS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [1:0]  cmd,
	input  logic [9:0]  first_slot,
	input  logic [31:0] first_gen,
	input  logic [9:0]  second_slot,
	input  logic [31:0] second_gen,
	input  logic        trigger_flag,
	input  logic        alive_flag,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [9:0]  self_slot,
	output logic [31:0] self_gen,
	output logic [9:0]  other_slot,
	output logic [31:0] other_gen,
	output logic        trigger_out,
	output logic        mirrored,
	output logic [31:0] tag_out,
	output logic        pair_dropped,
	output logic        last
);
	logic [cped_pkg::CAP_W-1:0] cap_q;
	logic [31:0]                tag_q;
	logic                       fq_valid, fq_stall, bq_valid, bq_take;
	cped_pkg::req_t             fq_req, bq_req;
	logic                       be_valid, be_stall;
	cped_pkg::evt_t             be_ev;
	// output hold register: one event held back so the next can flag it last
	cped_pkg::evt_t             hold_q;
	logic                       hold_v_q;
	logic                       marker, accept_be, out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cped_pkg::CAP_W'(1024);
			tag_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cped_pkg::CFG_CAPACITY: cap_q <= cfg_data[cped_pkg::CAP_W-1:0];
				cped_pkg::CFG_TAG:      tag_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cped_front u_front (
		.clk, .arst_n, .valid, .stall, .cmd, .first_slot, .first_gen, .second_slot,
		.second_gen, .trigger_flag, .alive_flag,
		.q_valid(fq_valid), .q_stall(fq_stall), .q_req(fq_req)
	);

	cped_queue u_queue (
		.clk, .arst_n, .in_valid(fq_valid), .in_stall(fq_stall), .in_req(fq_req),
		.out_valid(bq_valid), .out_take(bq_take), .out_req(bq_req)
	);

	cped_back #(.SLOT_COUNT(SLOT_COUNT), .MAX_PAIRS(MAX_PAIRS)) u_back (
		.clk, .arst_n, .q_valid(bq_valid), .q_take(bq_take), .q_req(bq_req),
		.capacity(cap_q), .ev_valid(be_valid), .ev_stall(be_stall), .ev(be_ev)
	);

	// end of frame marker: dropped and mirrored set on an exit code
	assign marker   = be_ev.dropped && be_ev.kind == cped_pkg::EV_COLL_EXIT;
	assign out_free = !hold_v_q || !out_stall;
	// a held event goes out once it is known to be last or a real event follows
	assign out_valid = hold_v_q && (hold_q.last || (be_valid && !marker));
	// a marker behind a held event is taken at once and only retags it
	assign be_stall = hold_v_q && out_stall && !(marker && !hold_q.last);
	assign accept_be = be_valid && !be_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			hold_q   <= '0;
		end else begin
			if (out_valid && !out_stall && !(accept_be && !marker)) begin
				hold_v_q <= 1'b0;
			end
			if (accept_be) begin
				if (marker) begin
					if (hold_v_q) begin
						hold_q.last <= 1'b1;
					end
				end else begin
					hold_v_q <= 1'b1;
					hold_q   <= be_ev;
				end
			end
		end
	end

	assign event_kind   = hold_q.kind;
	assign self_slot    = hold_q.ss;
	assign self_gen     = hold_q.sg;
	assign other_slot   = hold_q.os;
	assign other_gen    = hold_q.og;
	assign trigger_out  = hold_q.trig;
	assign mirrored     = hold_q.mir;
	assign tag_out      = tag_q;
	assign pair_dropped = hold_q.dropped;
	assign last         = hold_q.last;
endmodule
